FILE: rtl/core/rtfa_pkg.sv
// Shared types and constants for the region table first-fit allocator.
// No dependencies; used by rtfa_span_unit, the top level and the testbench.
package rtfa_pkg;

   localparam int ENTRY_COUNT_DEF = 256;
   localparam int ADDR_BITS_DEF   = 48;
   localparam int ALIGN_SHIFT_DEF = 21;

   localparam int CSR_IDX_W   = 2;
   localparam int ENTRY_OUT_W = 8;
   localparam int IDX_IN_W    = 8;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_REGIONS_START = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEV_CAPACITY  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL_LIMIT   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAPPING_LIMIT = 2'd3;

   // request types
   localparam logic [1:0] REQ_ALLOC = 2'd0;
   localparam logic [1:0] REQ_INIT  = 2'd1;
   localparam logic [1:0] REQ_FREE  = 2'd2;

   // result status
   localparam logic [1:0] STS_OK       = 2'd0;
   localparam logic [1:0] STS_INVALID  = 2'd1;
   localparam logic [1:0] STS_ALREADY  = 2'd2;
   localparam logic [1:0] STS_NO_SPACE = 2'd3;

   // entry states
   localparam logic [1:0] ENT_FREE      = 2'd0;
   localparam logic [1:0] ENT_ALLOCATED = 2'd2;

   typedef enum logic [9:0] {
      ST_CLEAR     = 10'b0000000001,
      ST_IDLE      = 10'b0000000010,
      ST_DISPATCH  = 10'b0000000100,
      ST_ALLOC     = 10'b0000001000,
      ST_INIT_CHK  = 10'b0000010000,
      ST_PASS_PREP = 10'b0000100000,
      ST_PASS      = 10'b0001000000,
      ST_PASS_END  = 10'b0010000000,
      ST_DONE      = 10'b0100000000,
      ST_HOLD      = 10'b1000000000
   } seq_state_type;

endpackage

FILE: rtl/core/rtfa_table.sv
// Region entry store: one write port, one read port with registered data.
// Word layout is {state, offset, size}. Depends on nothing else.
module rtfa_table #(
   parameter int DEPTH  = 256,
   parameter int WIDTH  = 98,
   parameter int AIDX_W = 8
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [AIDX_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data,
   input  logic              wr_en,
   input  logic [AIDX_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/rtfa_span_unit.sv
// Per-entry span check for first-fit search: filters valid spans, flags clear ones,
// marks blockers below cand + size and keeps the highest blocker end. Uses rtfa_pkg.
module rtfa_span_unit #(
   parameter int AB = 48
) (
   input  logic          clock,
   input  logic          clr,
   input  logic          en,
   input  logic [1:0]    ent_state,
   input  logic [AB-1:0] ent_offset,
   input  logic [AB-1:0] ent_size,
   input  logic [AB-1:0] dev_capacity,
   input  logic [AB+1:0] cand_end,
   output logic [AB-1:0] max_hi,
   output logic          any_clear
);

   logic [AB-1:0] max_hi_ff, max_hi_in;
   logic          any_clear_ff, any_clear_in;
   logic [AB:0]   hi;
   logic          span_ok;
   logic          blocks;

   always_comb begin
      hi      = {1'b0, ent_offset} + {1'b0, ent_size};
      span_ok = (ent_state == rtfa_pkg::ENT_ALLOCATED) && (ent_offset != '0) &&
                (ent_size != '0) && (hi <= {1'b0, dev_capacity});
      blocks  = {2'b00, ent_offset} < cand_end;
      max_hi_in    = max_hi_ff;
      any_clear_in = any_clear_ff;
      if (clr) begin
         max_hi_in    = '0;
         any_clear_in = 1'b0;
      end else if (en && span_ok) begin
         if (blocks) begin
            if (hi[AB-1:0] > max_hi_ff) begin
               max_hi_in = hi[AB-1:0];
            end
         end else begin
            any_clear_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      max_hi_ff    <= max_hi_in;
      any_clear_ff <= any_clear_in;
   end

   assign max_hi    = max_hi_ff;
   assign any_clear = any_clear_ff;

endmodule

FILE: rtl/core/region_table_first_fit_allocator_unit.sv
// Region table first-fit allocator, top level with the request sequencer.
// Uses rtfa_pkg, rtfa_table and rtfa_span_unit.
//
// Requests arrive on req_* (valid/stall), one result per request leaves on
// rsp_* (valid/stall). Registers are written on csr_* at any edge with
// csr_wr_en high; the user must write them only while the block is idle,
// which the block itself does not enforce. One request is worked on at a
// time; req_stall is low only when idle. A free, a bad type or a bad index
// goes straight to the result, and an init is first checked against its
// entry and may be rejected there. An alloc reads the table through its
// single read port from index 0 up to the lowest free entry, or through all
// of it when the table is full. An init that passes the checks runs P search
// passes, P being 1 plus the number of candidate moves; each pass scans the
// whole table once and moves the candidate past the blocking spans.
// After reset the table is cleared one entry a cycle, all ENTRY_COUNT
// entries, during which requests are stalled. A finished result waits in
// the output register while rsp_stall is high, and a new request can be
// taken while it waits; a later result is held until the output register
// is free, and requests stay stalled until that happens.
module region_table_first_fit_allocator_unit #(
   parameter int ENTRY_COUNT = rtfa_pkg::ENTRY_COUNT_DEF,
   parameter int ADDR_BITS   = rtfa_pkg::ADDR_BITS_DEF,
   parameter int ALIGN_SHIFT = rtfa_pkg::ALIGN_SHIFT_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [1:0]                       req_type,
   input  logic [rtfa_pkg::IDX_IN_W-1:0]    req_entry_index,
   input  logic [ADDR_BITS-1:0]             req_size,
   input  logic [ADDR_BITS-1:0]             req_offset,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [1:0]                       rsp_status,
   output logic [rtfa_pkg::ENTRY_OUT_W-1:0] rsp_entry_out,
   output logic [ADDR_BITS-1:0]             rsp_placed_offset,
   output logic [ADDR_BITS-1:0]             rsp_placed_size,
   input  logic                             csr_wr_en,
   input  logic [rtfa_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ADDR_BITS-1:0]             csr_wdata
);

   localparam int AB      = ADDR_BITS;
   localparam int IDX_W   = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
   localparam int ENT_W   = 2 + 2 * AB;
   localparam int EXT_W   = IDX_W + rtfa_pkg::IDX_IN_W + 1;
   localparam logic [IDX_W:0] N_L = (IDX_W + 1)'(ENTRY_COUNT);
   localparam logic [IDX_W:0] LAST_L = (IDX_W + 1)'(ENTRY_COUNT - 1);
   localparam logic [EXT_W-1:0] N_EXT = EXT_W'(ENTRY_COUNT);
   localparam logic [AB:0] ALIGN_MASK = (AB + 1)'((64'd1 << ALIGN_SHIFT) - 64'd1);

   rtfa_pkg::seq_state_type st_ff, st_in;

   logic [IDX_W:0]    ptr_ff, ptr_in;
   logic              rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]  rd_idx_ff, rd_idx_in;

   logic [1:0]        op_type_ff, op_type_in;
   logic [rtfa_pkg::IDX_IN_W-1:0] op_idx_ff, op_idx_in;
   logic [AB-1:0]     op_size_ff, op_size_in;
   logic [AB-1:0]     op_offset_ff, op_offset_in;

   logic [AB:0]       cand_ff, cand_in;
   logic [AB+1:0]     cand_end_ff, cand_end_in;

   logic [1:0]        res_status_ff, res_status_in;
   logic [rtfa_pkg::ENTRY_OUT_W-1:0] res_entry_ff, res_entry_in;
   logic [AB-1:0]     res_offset_ff, res_offset_in;
   logic [AB-1:0]     res_size_ff, res_size_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic [rtfa_pkg::ENTRY_OUT_W-1:0] rsp_entry_ff, rsp_entry_in;
   logic [AB-1:0]     rsp_offset_ff, rsp_offset_in;
   logic [AB-1:0]     rsp_size_ff, rsp_size_in;

   logic [AB-1:0]     regions_start_ff, dev_capacity_ff, total_limit_ff, mapping_limit_ff;

   logic              rd_en;
   logic [IDX_W-1:0]  rd_addr;
   logic [ENT_W-1:0]  rd_data;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic [ENT_W-1:0]  wr_data;

   logic              span_clr;
   logic              span_en;
   logic [AB-1:0]     max_hi;
   logic              any_clear;

   logic [1:0]        e_state;
   logic [AB-1:0]     e_offset;
   logic [AB-1:0]     e_size;
   logic [AB:0]       asz;
   logic [AB:0]       hi_ext;
   logic [AB:0]       hi_align;
   logic [EXT_W-1:0]  idx_ext;
   logic [IDX_W+rtfa_pkg::ENTRY_OUT_W-1:0] out_ext;
   logic              scan_more;
   logic              slot_free;
   logic              accept;

   assign e_state  = rd_data[ENT_W-1 -: 2];
   assign e_offset = rd_data[2*AB-1 -: AB];
   assign e_size   = rd_data[AB-1:0];

   assign asz      = ({1'b0, op_size_ff} + ALIGN_MASK) & ~ALIGN_MASK;
   assign hi_ext   = {1'b0, max_hi};
   assign hi_align = (hi_ext + ALIGN_MASK) & ~ALIGN_MASK;
   assign idx_ext  = {{(EXT_W - rtfa_pkg::IDX_IN_W){1'b0}}, op_idx_ff};
   assign out_ext  = {{rtfa_pkg::ENTRY_OUT_W{1'b0}}, rd_idx_ff};
   assign scan_more = ptr_ff < N_L;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign accept    = req_valid && (st_ff == rtfa_pkg::ST_IDLE);

   always_comb begin
      st_in         = st_ff;
      ptr_in        = ptr_ff;
      rd_vld_in     = 1'b0;
      rd_idx_in     = ptr_ff[IDX_W-1:0];
      op_type_in    = op_type_ff;
      op_idx_in     = op_idx_ff;
      op_size_in    = op_size_ff;
      op_offset_in  = op_offset_ff;
      cand_in       = cand_ff;
      cand_end_in   = cand_end_ff;
      res_status_in = res_status_ff;
      res_entry_in  = res_entry_ff;
      res_offset_in = res_offset_ff;
      res_size_in   = res_size_ff;
      rd_en         = 1'b0;
      rd_addr       = ptr_ff[IDX_W-1:0];
      wr_en         = 1'b0;
      wr_addr       = ptr_ff[IDX_W-1:0];
      wr_data       = '0;
      span_clr      = 1'b0;
      span_en       = 1'b0;

      unique case (st_ff)
         rtfa_pkg::ST_CLEAR: begin
            wr_en  = 1'b1;
            ptr_in = ptr_ff + 1'b1;
            if (ptr_ff == LAST_L) begin
               st_in = rtfa_pkg::ST_IDLE;
            end
         end
         rtfa_pkg::ST_IDLE: begin
            if (accept) begin
               op_type_in   = req_type;
               op_idx_in    = req_entry_index;
               op_size_in   = req_size;
               op_offset_in = req_offset;
               st_in        = rtfa_pkg::ST_DISPATCH;
            end
         end
         rtfa_pkg::ST_DISPATCH: begin
            res_status_in = rtfa_pkg::STS_INVALID;
            res_entry_in  = '0;
            res_offset_in = '0;
            res_size_in   = '0;
            ptr_in        = '0;
            st_in         = rtfa_pkg::ST_DONE;
            unique case (op_type_ff)
               rtfa_pkg::REQ_ALLOC: begin
                  st_in = rtfa_pkg::ST_ALLOC;
               end
               rtfa_pkg::REQ_FREE: begin
                  if (idx_ext < N_EXT) begin
                     wr_en         = 1'b1;
                     wr_addr       = idx_ext[IDX_W-1:0];
                     res_status_in = rtfa_pkg::STS_OK;
                  end
               end
               rtfa_pkg::REQ_INIT: begin
                  if (idx_ext < N_EXT && op_size_ff != '0) begin
                     rd_en   = 1'b1;
                     rd_addr = idx_ext[IDX_W-1:0];
                     st_in   = rtfa_pkg::ST_INIT_CHK;
                  end
               end
               default: begin
                  st_in = rtfa_pkg::ST_DONE;
               end
            endcase
         end
         rtfa_pkg::ST_ALLOC: begin
            if (scan_more) begin
               rd_en     = 1'b1;
               rd_vld_in = 1'b1;
               ptr_in    = ptr_ff + 1'b1;
            end
            priority if (rd_vld_ff && e_state == rtfa_pkg::ENT_FREE) begin
               wr_en         = 1'b1;
               wr_addr       = rd_idx_ff;
               wr_data       = {rtfa_pkg::ENT_ALLOCATED, op_offset_ff, op_size_ff};
               res_status_in = rtfa_pkg::STS_OK;
               res_entry_in  = out_ext[rtfa_pkg::ENTRY_OUT_W-1:0];
               st_in         = rtfa_pkg::ST_DONE;
            end else if (!scan_more && !rd_vld_ff) begin
               res_status_in = rtfa_pkg::STS_NO_SPACE;
               st_in         = rtfa_pkg::ST_DONE;
            end else begin
               st_in = rtfa_pkg::ST_ALLOC;
            end
         end
         rtfa_pkg::ST_INIT_CHK: begin
            st_in = rtfa_pkg::ST_DONE;
            priority if (e_state != rtfa_pkg::ENT_ALLOCATED) begin
               res_status_in = rtfa_pkg::STS_INVALID;
            end else if (e_offset != '0) begin
               res_status_in = rtfa_pkg::STS_ALREADY;
            end else if (op_size_ff > total_limit_ff || asz > {1'b0, total_limit_ff}) begin
               res_status_in = rtfa_pkg::STS_NO_SPACE;
            end else begin
               cand_in = {1'b0, regions_start_ff};
               st_in   = rtfa_pkg::ST_PASS_PREP;
            end
         end
         rtfa_pkg::ST_PASS_PREP: begin
            cand_end_in = {1'b0, cand_ff} + {1'b0, asz};
            ptr_in      = '0;
            span_clr    = 1'b1;
            st_in       = rtfa_pkg::ST_PASS;
         end
         rtfa_pkg::ST_PASS: begin
            if (scan_more) begin
               rd_en     = 1'b1;
               rd_vld_in = 1'b1;
               ptr_in    = ptr_ff + 1'b1;
            end
            span_en = rd_vld_ff;
            if (!scan_more && !rd_vld_ff) begin
               st_in = rtfa_pkg::ST_PASS_END;
            end
         end
         rtfa_pkg::ST_PASS_END: begin
            if (hi_ext > cand_ff) begin
               // blockers reach past the candidate: move it and rescan
               cand_in = hi_align;
               st_in   = rtfa_pkg::ST_PASS_PREP;
            end else begin
               st_in = rtfa_pkg::ST_DONE;
               if ((any_clear || cand_end_ff <= {2'b00, dev_capacity_ff}) &&
                   cand_end_ff <= {2'b00, mapping_limit_ff}) begin
                  wr_en         = 1'b1;
                  wr_addr       = idx_ext[IDX_W-1:0];
                  wr_data       = {rtfa_pkg::ENT_ALLOCATED, cand_ff[AB-1:0], asz[AB-1:0]};
                  res_status_in = rtfa_pkg::STS_OK;
                  res_offset_in = cand_ff[AB-1:0];
                  res_size_in   = asz[AB-1:0];
               end else begin
                  res_status_in = rtfa_pkg::STS_NO_SPACE;
               end
            end
         end
         rtfa_pkg::ST_DONE: begin
            if (slot_free) begin
               st_in = rtfa_pkg::ST_IDLE;
            end else begin
               st_in = rtfa_pkg::ST_HOLD;
            end
         end
         rtfa_pkg::ST_HOLD: begin
            if (slot_free) begin
               st_in = rtfa_pkg::ST_IDLE;
            end
         end
         default: begin
            st_in = rtfa_pkg::ST_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_entry_in  = rsp_entry_ff;
      rsp_offset_in = rsp_offset_ff;
      rsp_size_in   = rsp_size_ff;
      if ((st_ff == rtfa_pkg::ST_DONE || st_ff == rtfa_pkg::ST_HOLD) && slot_free) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_entry_in  = res_entry_ff;
         rsp_offset_in = res_offset_ff;
         rsp_size_in   = res_size_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= rtfa_pkg::ST_CLEAR;
         ptr_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         ptr_ff       <= ptr_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rd_idx_ff     <= rd_idx_in;
      op_type_ff    <= op_type_in;
      op_idx_ff     <= op_idx_in;
      op_size_ff    <= op_size_in;
      op_offset_ff  <= op_offset_in;
      cand_ff       <= cand_in;
      cand_end_ff   <= cand_end_in;
      res_status_ff <= res_status_in;
      res_entry_ff  <= res_entry_in;
      res_offset_ff <= res_offset_in;
      res_size_ff   <= res_size_in;
      rsp_status_ff <= rsp_status_in;
      rsp_entry_ff  <= rsp_entry_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_size_ff   <= rsp_size_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regions_start_ff <= '0;
         dev_capacity_ff  <= '0;
         total_limit_ff   <= '0;
         mapping_limit_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            rtfa_pkg::CSR_REGIONS_START: regions_start_ff <= csr_wdata;
            rtfa_pkg::CSR_DEV_CAPACITY:  dev_capacity_ff  <= csr_wdata;
            rtfa_pkg::CSR_TOTAL_LIMIT:   total_limit_ff   <= csr_wdata;
            rtfa_pkg::CSR_MAPPING_LIMIT: mapping_limit_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   rtfa_table #(
      .DEPTH  (ENTRY_COUNT),
      .WIDTH  (ENT_W),
      .AIDX_W (IDX_W)
   ) u_table (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   rtfa_span_unit #(
      .AB (AB)
   ) u_span (
      .clock        (clock),
      .clr          (span_clr),
      .en           (span_en),
      .ent_state    (e_state),
      .ent_offset   (e_offset),
      .ent_size     (e_size),
      .dev_capacity (dev_capacity_ff),
      .cand_end     (cand_end_ff),
      .max_hi       (max_hi),
      .any_clear    (any_clear)
   );

   assign req_stall         = (st_ff != rtfa_pkg::ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_entry_out     = rsp_entry_ff;
   assign rsp_placed_offset = rsp_offset_ff;
   assign rsp_placed_size   = rsp_size_ff;

   // the candidate only ever moves forward between passes
   a_cand_grows: assert property (@(posedge clock) disable iff (reset)
      (st_ff == rtfa_pkg::ST_PASS_END && hi_ext > cand_ff) |=> cand_ff > $past(cand_ff))
      else $error("search candidate did not advance");

   // committed init sizes are aligned
   a_size_aligned: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_size_ff & ALIGN_MASK[AB-1:0]) == '0))
      else $error("unaligned region size");

   // table is never written while idle
   a_no_idle_write: assert property (@(posedge clock) disable iff (reset)
      (st_ff == rtfa_pkg::ST_IDLE) |-> !wr_en)
      else $error("table write while idle");

   // a finished item reaches the output once the slot is free
   a_result_out: assert property (@(posedge clock) disable iff (reset)
      ((st_ff == rtfa_pkg::ST_DONE || st_ff == rtfa_pkg::ST_HOLD) && slot_free)
      |=> rsp_valid_ff)
      else $error("result lost");

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for region_table_first_fit_allocator_unit.
// Depends on rtfa_pkg and the RTL. A class keeps the table model and the queue of
// expected results; plain tasks drive requests and configuration writes.

typedef struct packed {
   logic [1:0]  status;
   logic [7:0]  entry;
   logic [47:0] offset;
   logic [47:0] size;
} region_result_type;

class region_book;
   localparam int unsigned SLOTS = 256;
   localparam longint unsigned ALIGN_M = (64'd1 << 21) - 64'd1;

   longint unsigned start_r, device_r, total_r, map_r;
   logic [1:0]      ent_state [SLOTS];
   longint unsigned ent_off   [SLOTS];
   longint unsigned ent_size  [SLOTS];
   region_result_type pending_q [$];
   int              errors, inits_ok, full_hits, items, results;

   function new();
      for (int i = 0; i < SLOTS; i++) begin
         ent_state[i] = rtfa_pkg::ENT_FREE;
         ent_off[i]   = 0;
         ent_size[i]  = 0;
      end
   endfunction

   function void set_reg(logic [1:0] idx, logic [47:0] val);
      case (idx)
         rtfa_pkg::CSR_REGIONS_START: start_r  = val;
         rtfa_pkg::CSR_DEV_CAPACITY:  device_r = val;
         rtfa_pkg::CSR_TOTAL_LIMIT:   total_r  = val;
         rtfa_pkg::CSR_MAPPING_LIMIT: map_r    = val;
         default: ;
      endcase
   endfunction

   function longint unsigned round_up(longint unsigned v);
      if (v > ~64'd0 - ALIGN_M) return ~64'd0;
      return (v + ALIGN_M) & ~ALIGN_M;
   endfunction

   function bit fits(longint unsigned a, longint unsigned b, longint unsigned lim);
      return b <= lim && a <= lim - b;
   endfunction

   // first fit over allocated spans sorted by offset (stable on ties)
   function bit find_gap(longint unsigned sz, output longint unsigned at);
      longint unsigned lo [SLOTS];
      longint unsigned hi [SLOTS];
      longint unsigned tl, th, cand;
      int n, j;
      n = 0;
      at = 0;
      for (int i = 0; i < SLOTS; i++) begin
         if (ent_state[i] != rtfa_pkg::ENT_ALLOCATED || ent_off[i] == 0 ||
             ent_size[i] == 0) continue;
         if (ent_size[i] > device_r || ent_off[i] > device_r - ent_size[i]) continue;
         lo[n] = ent_off[i];
         hi[n] = ent_off[i] + ent_size[i];
         n++;
      end
      for (int i = 1; i < n; i++) begin
         tl = lo[i];
         th = hi[i];
         j = i;
         while (j > 0 && lo[j-1] > tl) begin
            lo[j] = lo[j-1];
            hi[j] = hi[j-1];
            j--;
         end
         lo[j] = tl;
         hi[j] = th;
      end
      cand = start_r;
      for (int i = 0; i < n; i++) begin
         if (fits(cand, sz, lo[i])) begin
            at = cand;
            return 1;
         end
         if (hi[i] > cand) cand = round_up(hi[i]);
      end
      if (fits(cand, sz, device_r)) begin
         at = cand;
         return 1;
      end
      return 0;
   endfunction

   function void note_request(logic [1:0] kind, logic [7:0] idx, logic [47:0] size,
                              logic [47:0] offs);
      region_result_type r;
      longint unsigned asz, at;
      r = '0;
      r.status = rtfa_pkg::STS_INVALID;
      items++;
      if (kind == rtfa_pkg::REQ_ALLOC) begin
         r.status = rtfa_pkg::STS_NO_SPACE;
         for (int i = 0; i < SLOTS; i++) begin
            if (ent_state[i] == rtfa_pkg::ENT_FREE) begin
               ent_state[i] = rtfa_pkg::ENT_ALLOCATED;
               ent_off[i]   = offs;
               ent_size[i]  = size;
               r.entry  = i[7:0];
               r.status = rtfa_pkg::STS_OK;
               break;
            end
         end
         if (r.status == rtfa_pkg::STS_NO_SPACE) full_hits++;
      end else if (kind == rtfa_pkg::REQ_FREE) begin
         if (idx < SLOTS) begin
            ent_state[idx] = rtfa_pkg::ENT_FREE;
            ent_off[idx]   = 0;
            ent_size[idx]  = 0;
            r.status = rtfa_pkg::STS_OK;
         end
      end else if (kind == rtfa_pkg::REQ_INIT) begin
         if (idx >= SLOTS || size == 0 || ent_state[idx] != rtfa_pkg::ENT_ALLOCATED)
            r.status = rtfa_pkg::STS_INVALID;
         else if (ent_off[idx] != 0)
            r.status = rtfa_pkg::STS_ALREADY;
         else if (size > total_r)
            r.status = rtfa_pkg::STS_NO_SPACE;
         else begin
            asz = round_up(size);
            if (asz > total_r || !find_gap(asz, at) || !fits(at, asz, map_r))
               r.status = rtfa_pkg::STS_NO_SPACE;
            else begin
               ent_off[idx]  = at;
               ent_size[idx] = asz;
               r.offset = at;
               r.size   = asz;
               r.status = rtfa_pkg::STS_OK;
               inits_ok++;
            end
         end
      end
      pending_q.push_back(r);
   endfunction

   function void check_result(region_result_type got);
      region_result_type want;
      results++;
      if (pending_q.size() == 0) begin
         $display("%0t: unexpected result, got %h", $time, got);
         errors++;
         return;
      end
      want = pending_q.pop_front();
      if (got.status != want.status) begin
         $display("%0t: status exp %h got %h", $time, want.status, got.status);
         errors++;
      end
      if (got.entry != want.entry) begin
         $display("%0t: entry_out exp %h got %h", $time, want.entry, got.entry);
         errors++;
      end
      if (got.offset != want.offset) begin
         $display("%0t: placed_offset exp %h got %h", $time, want.offset, got.offset);
         errors++;
      end
      if (got.size != want.size) begin
         $display("%0t: placed_size exp %h got %h", $time, want.size, got.size);
         errors++;
      end
   endfunction

   // random allocated entry; with want_res only unplaced reservations
   function int pick_entry(bit want_res);
      int list [$];
      for (int i = 0; i < SLOTS; i++)
         if (ent_state[i] == rtfa_pkg::ENT_ALLOCATED && (!want_res || ent_off[i] == 0))
            list.push_back(i);
      if (list.size() == 0) return -1;
      return list[$urandom_range(0, list.size() - 1)];
   endfunction

   function int used_count();
      int c;
      c = 0;
      for (int i = 0; i < SLOTS; i++) if (ent_state[i] != rtfa_pkg::ENT_FREE) c++;
      return c;
   endfunction
endclass

module tb_top;
   localparam logic [1:0]  REQ_UNUSED = 2'd3;
   localparam longint      CYCLE_LIMIT = 200000000;
   localparam logic [47:0] MB2 = 48'h20_0000;
   localparam logic [47:0] ALL1 = {48{1'b1}};

   logic        clock, reset;
   logic        req_valid, req_stall;
   logic [1:0]  req_type;
   logic [7:0]  req_entry_index;
   logic [47:0] req_size, req_offset;
   logic        rsp_valid, rsp_stall;
   logic [1:0]  rsp_status;
   logic [7:0]  rsp_entry_out;
   logic [47:0] rsp_placed_offset, rsp_placed_size;
   logic        csr_wr_en;
   logic [1:0]  csr_index;
   logic [47:0] csr_wdata;

   region_book book;
   longint     cycles;
   int         burst_left, stall_mode, stall_hold;

   region_table_first_fit_allocator_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_type(req_type),
      .req_entry_index(req_entry_index), .req_size(req_size), .req_offset(req_offset),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
      .rsp_entry_out(rsp_entry_out), .rsp_placed_offset(rsp_placed_offset),
      .rsp_placed_size(rsp_placed_size),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic logic [47:0] rand48();
      return {16'($urandom), 32'($urandom)};
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // result side: check, then pick next stall value
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         book.check_result({rsp_status, rsp_entry_out, rsp_placed_offset, rsp_placed_size});
      if (cycles % 300 == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 2) == 0);
         default: begin
            if (stall_hold > 0) begin
               stall_hold <= stall_hold - 1;
               rsp_stall <= 1'b1;
            end else begin
               rsp_stall <= 1'b0;
               if ($urandom_range(0, 9) == 0) stall_hold <= $urandom_range(5, 40);
            end
         end
      endcase
   end

   task automatic write_reg(logic [1:0] idx, logic [47:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      book.set_reg(idx, val);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_regs(logic [47:0] st, logic [47:0] dev, logic [47:0] tot,
                           logic [47:0] map);
      write_reg(rtfa_pkg::CSR_REGIONS_START, st);
      write_reg(rtfa_pkg::CSR_DEV_CAPACITY, dev);
      write_reg(rtfa_pkg::CSR_TOTAL_LIMIT, tot);
      write_reg(rtfa_pkg::CSR_MAPPING_LIMIT, map);
   endtask

   // called right after a rising edge; returns after the accepting edge, or after a random idle gap behind it
   task automatic push(logic [1:0] kind, logic [7:0] idx, logic [47:0] size,
                       logic [47:0] offs);
      req_valid       <= 1'b1;
      req_type        <= kind;
      req_entry_index <= idx;
      req_size        <= size;
      req_offset      <= offs;
      do @(posedge clock); while (req_stall);
      book.note_request(kind, idx, size, offs);
      if (burst_left > 0) burst_left--;
      else begin
         burst_left = $urandom_range(0, 20);
         if ($urandom_range(0, 3) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (book.pending_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic random_items(int n);
      int r, e;
      logic [47:0] sz, off;
      for (int k = 0; k < n; k++) begin
         r = $urandom_range(0, 99);
         if (r < 35 && book.used_count() > 40) r = 80;
         if (r < 35) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4, 5: off = '0;
               6, 7, 8: off = 48'($urandom_range(1, 600)) * MB2 + 48'($urandom_range(0, 3)) * 1000;
               default: off = rand48();
            endcase
            sz = ($urandom_range(0, 4) != 0) ? 48'($urandom_range(1, 8 * 2097152)) : rand48();
            push(rtfa_pkg::REQ_ALLOC, 8'($urandom), sz, off);
         end else if (r < 70) begin
            e = book.pick_entry(1);
            if (e < 0 || $urandom_range(0, 4) == 0) e = $urandom_range(0, 255);
            case ($urandom_range(0, 19))
               0:       sz = '0;
               1, 2:    sz = rand48();
               default: sz = 48'($urandom_range(1, 8 * 2097152));
            endcase
            push(rtfa_pkg::REQ_INIT, 8'(e), sz, rand48());
         end else if (r < 95) begin
            e = book.pick_entry(0);
            if (e < 0 || $urandom_range(0, 3) == 0) e = $urandom_range(0, 255);
            push(rtfa_pkg::REQ_FREE, 8'(e), rand48(), rand48());
         end else
            push(REQ_UNUSED, 8'($urandom), rand48(), rand48());
      end
   endtask

   initial begin
      book = new();
      cycles = 0;
      burst_left = 0;
      stall_mode = 0;
      stall_hold = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_type = rtfa_pkg::REQ_ALLOC;
      req_entry_index = '0;
      req_size = '0;
      req_offset = '0;
      rsp_stall = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = rtfa_pkg::CSR_REGIONS_START;
      csr_wdata = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (req_stall) @(posedge clock);

      // registers at reset value: no region can be placed
      push(rtfa_pkg::REQ_ALLOC, 8'h00, MB2, '0);
      push(rtfa_pkg::REQ_INIT, 8'h00, 48'd1, '0);
      push(rtfa_pkg::REQ_INIT, 8'h00, '0, '0);
      push(REQ_UNUSED, 8'hFF, ALL1, ALL1);
      push(rtfa_pkg::REQ_FREE, 8'h00, '0, '0);
      drain();

      // directed search cases; table empty here
      set_regs(2 * MB2, 48'h8000_0000, 48'h1000_0000 - 48'd1000, 48'h8000_0000);
      push(rtfa_pkg::REQ_ALLOC, 8'h00, 3 * MB2 / 2, '0);                // e0 reservation
      push(rtfa_pkg::REQ_ALLOC, 8'h00, MB2, 2 * MB2);                   // e1 span
      push(rtfa_pkg::REQ_ALLOC, 8'h00, MB2 / 2, 2 * MB2);               // e2 same offset
      push(rtfa_pkg::REQ_ALLOC, 8'h00, 2 * MB2, 48'h8000_0000 - MB2 / 2); // e3 past end
      push(rtfa_pkg::REQ_INIT, 8'd0, 3 * MB2 / 2, '0);
      push(rtfa_pkg::REQ_INIT, 8'd0, MB2, '0);                          // already placed
      push(rtfa_pkg::REQ_INIT, 8'd9, MB2, '0);                          // free entry
      push(rtfa_pkg::REQ_ALLOC, 8'h00, '0, '0);                         // e4
      push(rtfa_pkg::REQ_INIT, 8'd4, '0, '0);
      push(rtfa_pkg::REQ_INIT, 8'd4, 48'h1000_0000 - 48'd999, '0);      // above limit
      push(rtfa_pkg::REQ_INIT, 8'd4, 48'h1000_0000 - 48'd1000, '0);     // aligned above
      push(rtfa_pkg::REQ_INIT, 8'd4, 48'd1, '0);
      push(rtfa_pkg::REQ_FREE, 8'd200, '0, '0);                         // free entry
      push(rtfa_pkg::REQ_FREE, 8'd1, '0, '0);
      drain();

      // tight mapping window, then start at zero so a region lands at offset zero
      set_regs(MB2, 48'h8000_0000, 48'h1000_0000, 6 * MB2);
      push(rtfa_pkg::REQ_ALLOC, 8'h00, '0, '0);
      push(rtfa_pkg::REQ_INIT, 8'd1, 8 * MB2, '0);
      drain();
      set_regs('0, 48'h8000_0000, 48'h1000_0000, 48'h8000_0000);
      push(rtfa_pkg::REQ_INIT, 8'd1, 48'd5, '0);
      push(rtfa_pkg::REQ_INIT, 8'd1, 48'd5, '0);
      drain();

      // extremes of every register, then fill the table past full
      set_regs(ALL1 - MB2, ALL1, ALL1, ALL1);
      push(rtfa_pkg::REQ_INIT, 8'd4, ALL1, '0);
      push(rtfa_pkg::REQ_INIT, 8'd0, MB2, '0);
      random_items(40);
      drain();
      while (book.used_count() < 256)
         push(rtfa_pkg::REQ_ALLOC, 8'($urandom), rand48(), '0);
      push(rtfa_pkg::REQ_ALLOC, 8'h00, MB2, MB2);
      push(rtfa_pkg::REQ_ALLOC, 8'h00, MB2, MB2);
      for (int i = 0; i < 256; i++)
         if (i % 5 != 0) push(rtfa_pkg::REQ_FREE, 8'(i), '0, '0);
      drain();

      set_regs(4 * MB2, 48'h4000_0000, 48'h0100_0000, 48'h4000_0000);
      random_items(20);
      drain();
      set_regs(MB2 + 48'd77, 48'h0400_0000, 8 * MB2 + 48'd3, 48'h0200_0000);
      random_items(20);
      drain();
      set_regs('0, ALL1, ALL1, ALL1);
      random_items(20);
      drain();
      set_regs(48'($urandom_range(0, 64)) * MB2, 48'h1_0000_0000, rand48(), 48'h8000_0000);
      random_items(15);
      drain();
      repeat (50) @(posedge clock);

      $display("%0d requests, %0d results, %0d regions placed, %0d table-full answers",
               book.items, book.results, book.inits_ok, book.full_hits);
      if (book.errors == 0 && book.pending_q.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
